FILE: design/layer_slot_allocator_defines.svh
// Assertion macros shared by the slot allocator modules.
`ifndef LAYER_SLOT_ALLOCATOR_DEFINES_SVH
`define LAYER_SLOT_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/lsa_pkg.sv
// Types, codes and default sizes of the layer slot allocator.
package lsa_pkg;

   localparam int SLOTS_DEF = 64;
   localparam int POOLS_DEF = 2;

   localparam int SLOT_W   = 6;
   localparam int LAYER_W  = 7;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [LAYER_W-1:0] layer_type;

   typedef enum logic [0:0] {
      ACT_ALLOC   = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      STAT_REUSED    = 3'd0,
      STAT_FRESH     = 3'd1,
      STAT_RELEASED  = 3'd2,
      STAT_DUPLICATE = 3'd3,
      STAT_EXHAUSTED = 3'd4
   } status_type;

   typedef struct packed {
      action_type action;
      logic       pool_type;
      slot_type   slot_in;
   } req_type;

   typedef struct packed {
      slot_type   slot_out;
      layer_type  layer_count;
      status_type status;
   } rsp_type;

   // Outcome of one request; a reused slot arrives later from the free-list memory.
   typedef struct packed {
      logic       reuse;
      slot_type   slot;
      layer_type  layer_count;
      status_type status;
   } dec_type;

endpackage

FILE: design/lsa_queue_mem.sv
// Free-list storage: one write port and one read port with registered read data.
module lsa_queue_mem #(
   parameter int DEPTH = lsa_pkg::SLOTS_DEF * lsa_pkg::POOLS_DEF,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: design/lsa_pool_ctrl.sv
// Per-pool queue pointers, high-water counts, membership bitmap and request decision.
`include "layer_slot_allocator_defines.svh"

module lsa_pool_ctrl #(
   parameter int SLOTS = lsa_pkg::SLOTS_DEF,
   parameter int POOLS = lsa_pkg::POOLS_DEF,
   parameter int IW    = $clog2(SLOTS),
   parameter int PW    = (POOLS > 1) ? $clog2(POOLS) : 1,
   parameter int AW    = $clog2(POOLS * SLOTS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             commit,
   input  lsa_pkg::req_type req,
   input  logic             clr_en,
   input  logic [PW-1:0]    clr_pool,
   input  logic [IW-1:0]    clr_slot,
   output logic [PW-1:0]    pool,
   output lsa_pkg::dec_type dec,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output logic [IW-1:0]    wr_data,
   output logic [AW-1:0]    rd_addr
);

   localparam int CW = $clog2(SLOTS + 1);
   localparam int TW = IW + 1;

   logic [POOLS-1:0][IW-1:0]    head_ff;
   logic [POOLS-1:0][CW-1:0]    fill_ff;
   logic [POOLS-1:0][CW-1:0]    hw_ff;
   logic [POOLS-1:0][SLOTS-1:0] mark_ff;

   logic [IW-1:0] head;
   logic [CW-1:0] fill;
   logic [CW-1:0] hw;
   logic [IW-1:0] head_in;
   logic [CW-1:0] fill_in;
   logic [CW-1:0] hw_in;
   logic [IW-1:0] head_next;
   logic [TW-1:0] tail_sum;
   logic [IW-1:0] tail;
   logic [IW-1:0] slot_idx;
   logic          in_range;
   logic          fwd_clear;
   logic          marked;
   logic          set_mark;

   assign pool     = (POOLS > 1) ? PW'(req.pool_type) : '0;
   assign head     = head_ff[pool];
   assign fill     = fill_ff[pool];
   assign hw       = hw_ff[pool];
   assign slot_idx = IW'(req.slot_in);
   assign in_range = (32'(req.slot_in) < SLOTS);

   // A reuse one stage ahead clears its bit at the edge this item commits.
   assign fwd_clear = clr_en && (clr_pool == pool) && (clr_slot == slot_idx);
   assign marked    = mark_ff[pool][slot_idx] && !fwd_clear;

   assign head_next = (head == IW'(SLOTS - 1)) ? '0 : head + 1'b1;

   always_comb begin
      tail_sum = TW'(head) + TW'(fill);
      if (tail_sum >= TW'(SLOTS)) begin
         tail_sum = tail_sum - TW'(SLOTS);
      end
      tail = IW'(tail_sum);
   end

   always_comb begin
      dec        = '0;
      dec.status = lsa_pkg::STAT_DUPLICATE;
      head_in    = head;
      fill_in    = fill;
      hw_in      = hw;
      set_mark   = 1'b0;
      unique case (req.action)
         lsa_pkg::ACT_ALLOC: begin
            if (fill != '0) begin
               dec.reuse  = 1'b1;
               dec.status = lsa_pkg::STAT_REUSED;
               head_in    = head_next;
               fill_in    = fill - 1'b1;
            end else if (hw < CW'(SLOTS)) begin
               dec.slot   = lsa_pkg::slot_type'(hw);
               dec.status = lsa_pkg::STAT_FRESH;
               hw_in      = hw + 1'b1;
            end else begin
               dec.status = lsa_pkg::STAT_EXHAUSTED;
            end
         end
         lsa_pkg::ACT_RELEASE: begin
            if (in_range && !marked && (fill < CW'(SLOTS))) begin
               dec.status = lsa_pkg::STAT_RELEASED;
               fill_in    = fill + 1'b1;
               set_mark   = 1'b1;
            end
         end
      endcase
      dec.layer_count = lsa_pkg::layer_type'(hw_in);
   end

   assign wr_en   = commit && set_mark;
   assign wr_data = slot_idx;
   assign wr_addr = AW'(pool) * AW'(SLOTS) + AW'(tail);
   assign rd_addr = AW'(pool) * AW'(SLOTS) + AW'(head);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         hw_ff   <= '0;
         mark_ff <= '0;
      end else begin
         // Clear before set so that a release of a just-reused slot wins.
         if (clr_en) begin
            mark_ff[clr_pool][clr_slot] <= 1'b0;
         end
         if (commit) begin
            head_ff[pool] <= head_in;
            fill_ff[pool] <= fill_in;
            hw_ff[pool]   <= hw_in;
            if (set_mark) begin
               mark_ff[pool][slot_idx] <= 1'b1;
            end
         end
      end
   end

   `LSA_ASSERT_NOW(a_fill_bound, commit, fill_ff[pool] <= CW'(SLOTS), "free list overfilled")
   `LSA_ASSERT_NEXT(a_release_marks, commit && set_mark, mark_ff[$past(pool)][$past(slot_idx)], "released slot not marked")
   `LSA_ASSERT_NEXT(a_hw_monotonic, commit, hw_ff[$past(pool)] >= $past(hw), "high-water count fell")

endmodule

FILE: design/layer_slot_allocator.sv
// Top level of the layer slot allocator: request pipeline and result register.
// The allocator keeps one FIFO free list per pool. An allocate reuses the
// oldest freed slot of the addressed pool, or else hands out the next fresh
// slot and raises that pool's high-water count, or reports exhaustion. A
// release queues the slot unless it is out of range or a membership bitmap
// shows it is already queued. The block takes one item per clock cycle while
// the result output is not stalled, and passes it through an input register,
// a decision stage that also reads the head of the free-list memory, and the
// result register; the read data is registered with the decision. No clearing
// pass is needed after reset, so items are taken from the first cycle on.
`include "layer_slot_allocator_defines.svh"

module layer_slot_allocator #(
   parameter int SLOTS = lsa_pkg::SLOTS_DEF,
   parameter int POOLS = lsa_pkg::POOLS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lsa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lsa_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(SLOTS);
   localparam int PW = (POOLS > 1) ? $clog2(POOLS) : 1;
   localparam int AW = $clog2(POOLS * SLOTS);

   // Stage one holds the accepted item, stage two its decision.
   logic             v1_ff;
   lsa_pkg::req_type req1_ff;
   logic             v2_ff;
   lsa_pkg::dec_type dec2_ff;
   logic [PW-1:0]    pool2_ff;
   logic             rsp_valid_ff;
   lsa_pkg::rsp_type rsp_ff;
   lsa_pkg::rsp_type rsp_in;

   logic             en1;
   logic             en2;
   logic             en3;
   logic             accept;
   logic             commit;
   logic             clr_en;

   logic [PW-1:0]    pool;
   lsa_pkg::dec_type dec;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [IW-1:0]    wr_data;
   logic [AW-1:0]    rd_addr;
   logic [IW-1:0]    rd_data;

   logic             reuse_held;
   logic             rsp_exhausted;

   // Each stage moves when the one after it is empty or moving itself.
   assign en3    = !rsp_valid_ff || !rsp_stall;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign accept = req_valid && en1;
   assign commit = v1_ff && en2;

   // A reused slot's membership bit is cleared when its decision moves on.
   assign clr_en = v2_ff && dec2_ff.reuse && en3;

   assign req_stall = !en1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   lsa_pool_ctrl #(
      .SLOTS (SLOTS),
      .POOLS (POOLS),
      .IW    (IW),
      .PW    (PW),
      .AW    (AW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .commit   (commit),
      .req      (req1_ff),
      .clr_en   (clr_en),
      .clr_pool (pool2_ff),
      .clr_slot (rd_data),
      .pool     (pool),
      .dec      (dec),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr)
   );

   lsa_queue_mem #(
      .DEPTH (POOLS * SLOTS),
      .WIDTH (IW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (commit),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // The granted slot of a reuse comes straight from the memory read register.
   always_comb begin
      rsp_in             = '0;
      rsp_in.slot_out    = dec2_ff.reuse ? lsa_pkg::slot_type'(rd_data) : dec2_ff.slot;
      rsp_in.layer_count = dec2_ff.layer_count;
      rsp_in.status      = dec2_ff.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req1_ff <= req_data;
      end
      if (commit) begin
         dec2_ff  <= dec;
         pool2_ff <= pool;
      end
      if (v2_ff && en3) begin
         rsp_ff <= rsp_in;
      end
   end

   // A waiting reuse must keep the slot it read from the free list.
   assign reuse_held    = v2_ff && dec2_ff.reuse && !en3;
   assign rsp_exhausted = rsp_valid_ff && (rsp_ff.status == lsa_pkg::STAT_EXHAUSTED);

   `LSA_ASSERT_NEXT(a_hold_read, reuse_held, v2_ff && $stable(rd_data), "read data lost")
   `LSA_ASSERT_NOW(a_exhausted_zero, rsp_exhausted, rsp_ff.slot_out == '0, "exhausted slot")

endmodule

FILE: bench/testbench.sv
// Self-checking testbench of the layer slot allocator: scoreboard, stimulus and watchdog.
module testbench;

   localparam int SLOTS           = lsa_pkg::SLOTS_DEF;
   localparam int POOLS           = lsa_pkg::POOLS_DEF;
   localparam int RESET_CYCLES    = 6;
   localparam int RANDOM_PHASES   = 6;
   localparam int PHASE_ITEMS     = 285;
   localparam int FILL_ITEMS      = 70;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int DRAIN_CYCLES    = 8;

   // The scoreboard mirrors the allocator: one circular free list per pool, its head and
   // fill count, the high-water count and the membership bitmap. Every accepted request
   // is run through this copy at once, and the outcome is queued until its result shows up.
   class slot_pool_scoreboard;
      lsa_pkg::slot_type free_list [POOLS][SLOTS];
      int unsigned       list_head [POOLS];
      int unsigned       list_fill [POOLS];
      int unsigned       high_water[POOLS];
      bit                on_list   [POOLS][SLOTS];
      lsa_pkg::rsp_type  outcome_q [$];
      int unsigned       failures;

      function new();
         for (int p = 0; p < POOLS; p++) begin
            list_head[p]  = 0;
            list_fill[p]  = 0;
            high_water[p] = 0;
            for (int s = 0; s < SLOTS; s++) begin
               free_list[p][s] = '0;
               on_list[p][s]   = 1'b0;
            end
         end
         failures = 0;
      endfunction

      function int unsigned pending();
         return outcome_q.size();
      endfunction

      function void note_request(lsa_pkg::req_type item);
         int unsigned      p;
         int unsigned      tail;
         lsa_pkg::rsp_type want;
         p    = item.pool_type % POOLS;
         want = '0;
         if (item.action == lsa_pkg::ACT_ALLOC) begin
            if (list_fill[p] != 0) begin
               // Oldest freed slot first; it leaves the bitmap as it leaves the list.
               want.slot_out = free_list[p][list_head[p]];
               on_list[p][want.slot_out] = 1'b0;
               list_head[p] = (list_head[p] + 1) % SLOTS;
               list_fill[p]--;
               want.status = lsa_pkg::STAT_REUSED;
            end else if (high_water[p] < SLOTS) begin
               want.slot_out = lsa_pkg::slot_type'(high_water[p]);
               high_water[p]++;
               want.status = lsa_pkg::STAT_FRESH;
            end else begin
               want.status = lsa_pkg::STAT_EXHAUSTED;
            end
         end else if (on_list[p][item.slot_in] || list_fill[p] >= SLOTS) begin
            want.status = lsa_pkg::STAT_DUPLICATE;
         end else begin
            // A slot that was never handed out is queued like any other.
            tail = (list_head[p] + list_fill[p]) % SLOTS;
            free_list[p][tail] = item.slot_in;
            on_list[p][item.slot_in] = 1'b1;
            list_fill[p]++;
            want.status = lsa_pkg::STAT_RELEASED;
         end
         want.layer_count = lsa_pkg::layer_type'(high_water[p]);
         outcome_q.insert(outcome_q.size(), want);
      endfunction

      function void check_response(lsa_pkg::rsp_type got);
         lsa_pkg::rsp_type want;
         if (outcome_q.size() == 0) begin
            $error("result with no request outstanding: slot_out %0d layer_count %0d status %0d",
                   got.slot_out, got.layer_count, got.status);
            failures++;
            return;
         end
         want = outcome_q[0];
         outcome_q.delete(0);
         if (got.slot_out !== want.slot_out) begin
            $error("slot_out expected %0d actual %0d", want.slot_out, got.slot_out);
            failures++;
         end
         if (got.layer_count !== want.layer_count) begin
            $error("layer_count expected %0d actual %0d", want.layer_count, got.layer_count);
            failures++;
         end
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            failures++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lsa_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b1;
   lsa_pkg::rsp_type rsp_data;

   // Idling percentages of the current phase, set by the stimulus process.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // Each flip of this bit asks the receiver for one long hold-off.
   logic hold_off_toggle = 1'b0;

   slot_pool_scoreboard sb = new();

   layer_slot_allocator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Offers one item, with random idle cycles in front of it, and returns at the edge
   // where it was taken. The valid stays high on return, so back-to-back items need no gap.
   task automatic send_item(input lsa_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic lsa_pkg::req_type make_req(lsa_pkg::action_type act, int unsigned pool,
                                                 int unsigned slot);
      lsa_pkg::req_type item;
      item.action    = act;
      item.pool_type = pool[0];
      item.slot_in   = lsa_pkg::slot_type'(slot);
      return item;
   endfunction

   // Random request. Releases mostly name slots that the pool has already handed out,
   // so that the free lists really fill and drain; the rest name any slot at all.
   function automatic lsa_pkg::req_type random_request(int unsigned alloc_pct,
                                                       int unsigned focus);
      int unsigned pool;
      int unsigned slot;
      pool = ($urandom_range(99) < 75) ? focus : $urandom_range(POOLS - 1);
      if (sb.high_water[pool] > 0 && $urandom_range(99) < 70)
         slot = $urandom_range(sb.high_water[pool] - 1);
      else
         slot = $urandom_range(SLOTS - 1);
      return make_req(($urandom_range(99) < alloc_pct) ? lsa_pkg::ACT_ALLOC :
                      lsa_pkg::ACT_RELEASE, pool, slot);
   endfunction

   // The receiver stalls at random by the phase percentage. When asked for a hold-off it
   // keeps the stall up for a long stretch that it counts itself, while the sender goes on
   // offering items, so that the pipeline fills and the block stalls its input.
   initial begin : receiver
      logic seen_toggle;
      seen_toggle = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_toggle != seen_toggle) begin
            seen_toggle = hold_off_toggle;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Both channels are sampled at the clock edge, before any of that edge's updates land.
   // Accepted requests feed the predictor, accepted results are checked against it, and a
   // long run of cycles without any transfer ends the run as a hang.
   always @(posedge clock) begin : check_and_watch
      int unsigned quiet_cycles;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_data);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned sent;
      int unsigned burst_len;
      int unsigned alloc_pct;
      int unsigned focus;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part: fresh grants in both pools, a release and its duplicate, the release
      // of a slot never granted (all ones in the slot field), reuse in release order, and
      // fresh grants resuming once the free list is empty again.
      send_item(make_req(lsa_pkg::ACT_ALLOC,   0, 0));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   1, 63));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   0, 21));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   0, 42));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 0, 0));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 0, 0));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 0, 63));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 1, 63));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 1, 63));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 0, 2));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   0, 0));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   0, 0));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 0, 0));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   1, 0));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   1, 0));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   0, 0));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   0, 0));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   0, 0));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 1, 0));
      send_item(make_req(lsa_pkg::ACT_RELEASE, 1, 1));
      send_item(make_req(lsa_pkg::ACT_ALLOC,   1, 63));

      // Back pressure: the receiver holds off while pool 1 is allocated until it is
      // exhausted, which also covers the full-pool case.
      hold_off_toggle <= ~hold_off_toggle;
      for (int n = 0; n < FILL_ITEMS; n++) begin
         send_item(make_req(lsa_pkg::ACT_ALLOC, 1, $urandom_range(SLOTS - 1)));
      end

      // Random part in phases of idling. Each phase is made of bursts that lean towards
      // allocation, towards release or neither, mostly on one pool, so that the free lists
      // swing between empty and crowded.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 58;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 58;
            end
            default: begin
               send_idle_pct  = 22;
               recv_stall_pct = 22;
            end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst_len = $urandom_range(10, 60);
            if (burst_len > PHASE_ITEMS - sent) begin
               burst_len = PHASE_ITEMS - sent;
            end
            focus = $urandom_range(POOLS - 1);
            case ($urandom_range(2))
               0:       alloc_pct = 90;
               1:       alloc_pct = 50;
               default: alloc_pct = 15;
            endcase
            repeat (burst_len) begin
               send_item(random_request(alloc_pct, focus));
               sent++;
            end
         end
      end

      req_valid      <= 1'b0;
      recv_stall_pct  = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      // A drain wait then catches any result the block sends beyond the expected ones.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
